// File: rtl/edv_pkg.sv
// shared constants and types of the edge vertex dedup block
`default_nettype none
package edv_pkg;

  localparam int SIDE_DEF         = 16;
  localparam int MAX_VERTICES_DEF = 16384;

  localparam int EPOCH_W   = 8;
  localparam int AXIS_W    = 2;
  localparam int COORD_IN_W = 5;
  localparam int TAG_W     = 32;
  localparam int VINDEX_W  = 14;

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 48;

  typedef enum logic [0:0] {
    KIND_CORNER = 1'b0,
    KIND_PATCH  = 1'b1
  } kind_t;

  localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

endpackage
`default_nettype wire

// File: rtl/edge_vertex_dedup_core.sv
// top level of the edge vertex dedup block
// results pass through the s1 stage and the output register, one result per input
// throughput: one item per cycle while the output does not stall and no clearing pass runs,
// set by the single table read-modify-write per corner with forwarding of the last table write
// reset: synchronous; a clearing pass over all 3*(SIDE+1)^3 table entries follows reset and
// every 255th new patch, during which no item is taken
`default_nettype none
module edge_vertex_dedup_core #(
  parameter int SIDE         = edv_pkg::SIDE_DEF,
  parameter int MAX_VERTICES = edv_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_wdata,  // allow_duplicates
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // edge_axis, cell_x, cell_y, cell_z, vertex_tag, zero fill
  input  wire logic [edv_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind
  input  wire logic [edv_pkg::S_TUSER_W-1:0]  s_tuser,
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  // vertex_index, is_new, tag_out, overflow
  output      logic [edv_pkg::M_TDATA_W-1:0]  m_tdata
);
  import edv_pkg::*;

  localparam int P       = SIDE + 1;
  localparam int DEPTH   = 3 * P * P * P;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int ENTRY_W = EPOCH_W + IDX_W;

  logic                allow_dup;
  logic                sweeping;
  logic [SLOT_W-1:0]   sweep_addr;
  logic [EPOCH_W-1:0]  epoch;
  logic [CNT_W-1:0]    count;

  logic                s1_valid;
  kind_t               s1_kind;
  logic [SLOT_W-1:0]   s1_slot;
  logic [TAG_W-1:0]    s1_tag;

  logic                fwd_valid;
  logic [SLOT_W-1:0]   fwd_slot;
  logic [IDX_W-1:0]    fwd_index;

  logic [VINDEX_W-1:0] out_index;
  logic                out_new;
  logic [TAG_W-1:0]    out_tag;
  logic                out_ovf;

  logic [SLOT_W-1:0]   in_slot;
  logic                accept;
  logic                s1_done;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [EPOCH_W-1:0]  stored_epoch;
  logic [IDX_W-1:0]    stored_index;
  logic                hit;
  logic                full;
  logic                do_count;
  logic                do_store;
  logic [VINDEX_W-1:0] res_index;
  logic                res_new;
  logic                res_ovf;

  // slot of the incoming corner
  always_comb begin
    int ax;
    int cx;
    int cy;
    int cz;
    ax = (s_tdata[1:0] == AXIS_SPARE) ? int'(AXIS_Z) : int'(s_tdata[1:0]);
    cx = int'(s_tdata[6:2]);
    cy = int'(s_tdata[11:7]);
    cz = int'(s_tdata[16:12]);
    if (cx > SIDE) cx = SIDE;
    if (cy > SIDE) cy = SIDE;
    if (cz > SIDE) cz = SIDE;
    in_slot = SLOT_W'(((ax * P + cx) * P + cy) * P + cz);
  end

  assign s1_done  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !sweeping
                    && !(s1_valid && s1_kind == KIND_PATCH && (&epoch))
                    && (!s1_valid || s1_done);
  assign accept   = s_tvalid && s_tready;

  // lookup and decision for the item in flight
  always_comb begin
    if (fwd_valid && fwd_slot == s1_slot) begin
      stored_epoch = epoch;
      stored_index = fwd_index;
    end else begin
      stored_epoch = ram_rdata[ENTRY_W-1:IDX_W];
      stored_index = ram_rdata[IDX_W-1:0];
    end
    hit  = !allow_dup && stored_epoch == epoch;
    full = count >= CNT_W'(MAX_VERTICES);
    res_index = '0;
    res_new   = 1'b0;
    res_ovf   = 1'b0;
    if (s1_kind == KIND_CORNER) begin
      if (hit) begin
        res_index = VINDEX_W'(stored_index);
      end else if (full) begin
        res_ovf = 1'b1;
      end else begin
        res_index = VINDEX_W'(count);
        res_new   = 1'b1;
      end
    end
    do_count = s1_done && res_new;
    do_store = do_count && !allow_dup;
  end

  always_comb begin
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = do_store;
      ram_waddr = s1_slot;
      ram_wdata = {epoch, count[IDX_W-1:0]};
    end
  end

  edv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_dup  <= 1'b0;
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      epoch      <= EPOCH_W'(1);
      count      <= '0;
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        allow_dup <= cfg_wdata;
      end

      if (sweeping) begin
        if (sweep_addr == SLOT_W'(DEPTH - 1)) begin
          sweeping <= 1'b0;
        end else begin
          sweep_addr <= sweep_addr + SLOT_W'(1);
        end
      end

      if (s1_done) begin
        m_tvalid  <= 1'b1;
        out_index <= res_index;
        out_new   <= res_new;
        out_tag   <= s1_tag;
        out_ovf   <= res_ovf;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (accept) begin
        s1_valid <= 1'b1;
        s1_kind  <= kind_t'(s_tuser[0]);
        s1_slot  <= in_slot;
        s1_tag   <= s_tdata[48:17];
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end

      if (s1_done && s1_kind == KIND_PATCH) begin
        count     <= '0;
        fwd_valid <= 1'b0;
        if (&epoch) begin
          epoch      <= EPOCH_W'(1);
          sweeping   <= 1'b1;
          sweep_addr <= '0;
        end else begin
          epoch <= epoch + EPOCH_W'(1);
        end
      end

      if (do_count) begin
        count <= count + CNT_W'(1);
      end
      if (do_store) begin
        fwd_valid <= 1'b1;
        fwd_slot  <= s1_slot;
        fwd_index <= count[IDX_W-1:0];
      end
    end
  end

  assign m_tdata = {out_ovf, out_tag, out_new, out_index};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_patch_clears: assert property (@(posedge clk) disable iff (rst)
    s1_done && s1_kind == KIND_PATCH |=> count == '0)
    else $error("new patch did not clear count");

  a_fresh_counts: assert property (@(posedge clk) disable iff (rst)
    s1_done && res_new |=> count == $past(count) + CNT_W'(1))
    else $error("fresh vertex did not advance count");

  a_ovf_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_ovf |-> !out_new && out_index == '0)
    else $error("overflow result carries an index");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch reached the cleared mark");

endmodule
`default_nettype wire

// File: rtl/edv_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module edv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the edge vertex dedup core: streamed corners and patches against a predictor
`default_nettype none
module tb_top;
  import edv_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int PLANE        = SIDE_DEF + 1;
  localparam int SLOT_COUNT   = 3 * PLANE * PLANE * PLANE;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    kind_t                 kind;
    logic [AXIS_W-1:0]     axis;
    logic [COORD_IN_W-1:0] x;
    logic [COORD_IN_W-1:0] y;
    logic [COORD_IN_W-1:0] z;
    logic [TAG_W-1:0]      tag;
  } mesh_item_t;

  typedef struct {
    logic [VINDEX_W-1:0] vidx;
    logic                is_new;
    logic [TAG_W-1:0]    tag;
    logic                ovf;
  } vertex_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic                 cfg_wdata = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  edge_vertex_dedup_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // predictor state
  int             slot_patch [SLOT_COUNT];
  logic [VINDEX_W-1:0] slot_vidx [SLOT_COUNT];
  int             patch_no = 1;
  int             vtx_count = 0;
  bit             dup_mode = 1'b0;

  mesh_item_t     pending_items [$];
  vertex_result_t due_results [$];
  mesh_item_t     on_bus;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int pressure_req = 0;
  int pressure_seen = 0;
  int hold_left = 0;

  int err_count = 0;
  int n_checked = 0;
  int n_patches = 0;
  int n_corners = 0;
  int n_hits = 0;
  int n_ovf = 0;

  mesh_item_t recent [8];
  int         recent_wr = 0;

  function automatic int sat_coord(logic [COORD_IN_W-1:0] c);
    return (c > SIDE_DEF) ? SIDE_DEF : int'(c);
  endfunction

  function automatic vertex_result_t assign_vertex(mesh_item_t it);
    vertex_result_t r;
    logic [AXIS_W-1:0] ax;
    int slot;
    r.vidx = '0;
    r.is_new = 1'b0;
    r.tag = it.tag;
    r.ovf = 1'b0;
    ax = (it.axis == AXIS_SPARE) ? AXIS_Z : it.axis;
    if (it.kind == KIND_PATCH) begin
      patch_no++;
      vtx_count = 0;
      n_patches++;
    end else begin
      n_corners++;
      slot = ((int'(ax) * PLANE + sat_coord(it.x)) * PLANE + sat_coord(it.y)) * PLANE
             + sat_coord(it.z);
      if (!dup_mode && slot_patch[slot] == patch_no) begin
        r.vidx = slot_vidx[slot];
        n_hits++;
      end else if (vtx_count >= MAX_VERTICES_DEF) begin
        r.ovf = 1'b1;
        n_ovf++;
      end else begin
        r.vidx = vtx_count[VINDEX_W-1:0];
        r.is_new = 1'b1;
        vtx_count++;
        if (!dup_mode) begin
          slot_patch[slot] = patch_no;
          slot_vidx[slot] = r.vidx;
        end
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    mesh_item_t it;
    vertex_result_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        res = assign_vertex(on_bus);
        due_results = {due_results, res};
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          it = pending_items.pop_front();
          on_bus <= it;
          s_tvalid <= 1'b1;
          s_tuser <= it.kind;
          s_tdata <= {7'b0, it.tag, it.z, it.y, it.x, it.axis};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (pressure_req != pressure_seen) begin
      pressure_seen <= pressure_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : watch_proc
    vertex_result_t want;
    vertex_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.vidx = m_tdata[13:0];
      got.is_new = m_tdata[14];
      got.tag = m_tdata[46:15];
      got.ovf = m_tdata[47];
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result transaction, got %h", $time, m_tdata);
        err_count++;
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (got.vidx !== want.vidx) begin
          $display("%0t: vertex_index expected %0d actual %0d", $time, want.vidx, got.vidx);
          err_count++;
        end
        if (got.is_new !== want.is_new) begin
          $display("%0t: is_new expected %0d actual %0d", $time, want.is_new, got.is_new);
          err_count++;
        end
        if (got.tag !== want.tag) begin
          $display("%0t: tag_out expected %h actual %h", $time, want.tag, got.tag);
          err_count++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, got.ovf);
          err_count++;
        end
      end
    end
  end

  task automatic offer_patch(logic [TAG_W-1:0] tag);
    mesh_item_t it;
    it.kind = KIND_PATCH;
    it.axis = AXIS_W'($urandom_range(3));
    it.x = COORD_IN_W'($urandom_range(31));
    it.y = COORD_IN_W'($urandom_range(31));
    it.z = COORD_IN_W'($urandom_range(31));
    it.tag = tag;
    pending_items = {pending_items, it};
  endtask

  task automatic offer_corner(int ax, int cx, int cy, int cz, logic [TAG_W-1:0] tag);
    mesh_item_t it;
    it.kind = KIND_CORNER;
    it.axis = AXIS_W'(ax);
    it.x = COORD_IN_W'(cx);
    it.y = COORD_IN_W'(cy);
    it.z = COORD_IN_W'(cz);
    it.tag = tag;
    pending_items = {pending_items, it};
  endtask

  // checked between edges so that every update of the last edge is visible
  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_dup_mode(bit v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dup_mode = v;
  endtask

  task automatic set_idling(int src_pct, int sink_pct);
    @(posedge clk);
    src_idle_pct <= src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // mostly patches of corners that share edges, some far-flung and saturating ones
  task automatic offer_random(int n);
    mesh_item_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        offer_patch($urandom);
      end else if (pick < 50) begin
        it = recent[$urandom_range(7)];
        offer_corner(it.axis, it.x, it.y, it.z, $urandom);
      end else begin
        it.kind = KIND_CORNER;
        it.axis = AXIS_W'($urandom_range(3));
        if (pick < 88) begin
          it.x = COORD_IN_W'($urandom_range(3));
          it.y = COORD_IN_W'($urandom_range(3));
          it.z = COORD_IN_W'($urandom_range(3));
        end else begin
          it.x = COORD_IN_W'($urandom_range(31));
          it.y = COORD_IN_W'($urandom_range(31));
          it.z = COORD_IN_W'($urandom_range(31));
        end
        it.tag = $urandom;
        recent[recent_wr] = it;
        recent_wr = (recent_wr + 1) % 8;
        pending_items = {pending_items, it};
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      recent[i].kind = KIND_CORNER;
      recent[i].axis = AXIS_W'(i % 4);
      recent[i].x = COORD_IN_W'(i);
      recent[i].y = '0;
      recent[i].z = COORD_IN_W'(16 + i);
      recent[i].tag = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_dup_mode(1'b0);

    // directed: extremes, axis aliasing, saturation, patch clearing
    offer_patch(32'h0000_0000);
    offer_corner(0, 0, 0, 0, 32'h0000_0000);
    offer_corner(0, 0, 0, 0, 32'hFFFF_FFFF);
    offer_corner(1, 0, 0, 0, 32'h8000_0001);
    offer_corner(2, 16, 16, 16, 32'h5555_5555);
    offer_corner(3, 16, 16, 16, 32'hAAAA_AAAA);
    offer_corner(0, 31, 31, 31, 32'h0F0F_0F0F);
    offer_corner(0, 16, 16, 16, 32'hF0F0_F0F0);
    offer_corner(1, 17, 5, 20, 32'h1234_5678);
    offer_corner(1, 16, 5, 16, 32'h8765_4321);
    offer_corner(2, 5, 31, 0, 32'hDEAD_BEEF);
    offer_corner(3, 0, 0, 0, 32'hCAFE_F00D);
    offer_patch(32'hFFFF_FFFF);
    offer_corner(0, 0, 0, 0, 32'h0000_0001);
    offer_corner(2, 16, 16, 16, 32'h0000_0002);
    offer_corner(0, 0, 0, 0, 32'h0000_0003);

    // random phases with different idling and mode settings
    offer_random(40);
    write_dup_mode(1'b1);
    set_idling(52, 0);
    offer_random(40);
    write_dup_mode(1'b0);
    set_idling(0, 52);
    offer_random(20);
    @(posedge clk);
    pressure_req <= pressure_req + 1;
    offer_random(20);
    write_dup_mode(1'b1);
    set_idling(10, 10);
    offer_random(40);
    write_dup_mode(1'b0);
    set_idling(0, 0);

    // many patches in a row, past the epoch wrap: no entry may outlive its patch
    for (int i = 0; i < 260; i++) begin
      offer_patch($urandom);
      if (i % 8 == 0)
        offer_corner((i / 8) % 4, 3, 7, 11, $urandom);
      if (i % 32 == 0)
        offer_corner((i / 8) % 4, 3, 7, 11, $urandom);
    end
    offer_corner(1, 9, 9, 9, $urandom);
    offer_corner(1, 9, 9, 9, $urandom);
    offer_patch($urandom);
    offer_corner(1, 9, 9, 9, $urandom);

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d corners (%0d table hits, %0d overflows) across %0d new patches",
             n_corners, n_hits, n_ovf, n_patches);
    $display("%0d result transactions checked, %0d mismatches", n_checked, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("timeout with %0d results outstanding", due_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
